// ===== hw/rtl/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

	localparam int ID_W   = 22;
	localparam int TIME_W = 16;
	localparam int PRIO_W = 8;
	localparam int STAT_W = 2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_RUN  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_WAIT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// one wait queue entry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] tm;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// running results of one pass over the queue
	typedef struct packed {
		logic hit;    // caller id found
		logic less;   // some waiter beats the runner's priority
		logic found;  // first entry with larger priority seen
	} scan_flags_t;

endpackage

// ===== hw/rtl/pps_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module pps_ram #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/pps_scan.sv =====
// Compare unit: checks one queue entry per cycle and accumulates search results.
module pps_scan #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          vld,
	input  logic [$clog2(DEPTH)-1:0]      idx,
	input  pps_pkg::entry_t               ent,
	input  logic [pps_pkg::ID_W-1:0]      key_id,
	input  logic [pps_pkg::PRIO_W-1:0]    key_prio,
	input  logic [pps_pkg::PRIO_W-1:0]    run_prio,
	output pps_pkg::scan_flags_t          flags,
	output logic [$clog2(DEPTH)-1:0]      hit_idx,
	output logic [$clog2(DEPTH)-1:0]      pos_idx,
	output pps_pkg::entry_t               head
);

	pps_pkg::scan_flags_t            flags_q;
	logic [$clog2(DEPTH)-1:0]        hit_idx_q;
	logic [$clog2(DEPTH)-1:0]        pos_idx_q;
	pps_pkg::entry_t                 head_q;
	logic                            hit_now;
	logic                            less_now;
	logic                            pos_now;

	// first match only for id and insert point
	assign hit_now  = vld && !flags_q.hit && (ent.id == key_id);
	assign less_now = vld && (ent.prio < run_prio);
	assign pos_now  = vld && !flags_q.found && (ent.prio > key_prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else begin
			if (hit_now) flags_q.hit <= 1'b1;
			if (less_now) flags_q.less <= 1'b1;
			if (pos_now) flags_q.found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) hit_idx_q <= idx;
		if (pos_now) pos_idx_q <= idx;
		if (vld && (idx == '0)) head_q <= ent;
	end

	assign flags   = flags_q;
	assign hit_idx = hit_idx_q;
	assign pos_idx = pos_idx_q;
	assign head    = head_q;

endmodule

// ===== hw/rtl/preemptive_priority_scheduler_unit.sv =====
// Top level of the preemptive priority scheduler: sequencer, runner state, wait queue.
//
// channel   direction  handshake                 word
// request   in         start & !busy             caller_id, job_time, job_priority
// result    out        done (one cycle, no hold) status, running_valid, running_id
//
// One request at a time; busy stays high from acceptance until the done cycle,
// and a new request may be taken in the done cycle itself.
// A grant, update or refusal takes one scan over the N waiters; a removal also shifts
// every entry behind the removed one, an insertion every entry behind the insert point;
// a preemption runs scan, removal, a second scan and insertion. The single compare unit
// and the one read port of the queue RAM, one entry per cycle, set the pace of each pass.
// Reset clears the runner and the queue count; queue RAM contents need no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
module preemptive_priority_scheduler_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pps_pkg::ID_W-1:0]      caller_id,
	input  logic [pps_pkg::TIME_W-1:0]    job_time,
	input  logic [pps_pkg::PRIO_W-1:0]    job_priority,
	output logic                          done,
	output logic [pps_pkg::STAT_W-1:0]    status,
	output logic                          running_valid,
	output logic [pps_pkg::ID_W-1:0]      running_id
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SHDN   = 3'd3;
	localparam logic [2:0] ST_SHUP   = 3'd4;
	localparam logic [2:0] ST_PUT    = 3'd5;

	logic [2:0]                    state_q;
	logic [CW-1:0]                 count_q;   // waiters in queue
	logic [CW-1:0]                 ptr_q;     // read pointer for scan and shifts
	logic [CW-1:0]                 pos_q;     // insert point
	logic                          pre_q;     // preemption: second pass inserts old runner
	logic                          done_q;
	logic [pps_pkg::STAT_W-1:0]    status_q;

	// runner
	logic                          run_valid_q;
	logic [pps_pkg::ID_W-1:0]      run_id_q;
	logic [pps_pkg::TIME_W-1:0]    run_rem_q;
	logic [pps_pkg::PRIO_W-1:0]    run_prio_q;

	// latched request
	logic [pps_pkg::ID_W-1:0]      in_id_q;
	logic [pps_pkg::TIME_W-1:0]    in_time_q;
	logic [pps_pkg::PRIO_W-1:0]    in_prio_q;

	// RAM read pipeline
	logic                          rvld_s1;
	logic [AW-1:0]                 ridx_s1;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	pps_pkg::entry_t               ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	pps_pkg::entry_t               ram_rdata;

	pps_pkg::scan_flags_t          flags;
	logic [AW-1:0]                 hit_idx;
	logic [AW-1:0]                 pos_idx;
	pps_pkg::entry_t               head;

	logic                          accept;
	logic                          scan_clr;
	logic                          scan_vld;
	logic                          is_fin;
	logic                          own;
	logic                          do_upd;
	logic                          preempt_go;
	logic                          shdn_end;
	pps_pkg::entry_t               new_ent;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign is_fin  = (in_time_q == '0);
	assign own     = run_valid_q && (in_id_q == run_id_q);
	assign new_ent = '{id: in_id_q, tm: in_time_q, prio: in_prio_q};

	// in-place rewrite of an existing waiter
	assign do_upd     = !pre_q && !is_fin && run_valid_q && !own && flags.hit;
	// runner renewed while a waiter has strictly better priority
	assign preempt_go = !pre_q && !is_fin && own && flags.less;

	assign shdn_end = (state_q == ST_SHDN) && (ptr_q == count_q) && !rvld_s1;
	assign scan_clr = accept || (shdn_end && pre_q);
	assign scan_vld = rvld_s1 && (state_q == ST_SCAN);

	// queue RAM port steering
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = ridx_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_SCAN: begin
				ram_re = (ptr_q != count_q);
			end
			ST_DECIDE: begin
				ram_we    = do_upd;
				ram_waddr = hit_idx;
				ram_wdata = new_ent;
			end
			ST_SHDN: begin
				// move entry up one slot toward the head
				ram_re    = (ptr_q != count_q);
				ram_we    = rvld_s1;
				ram_waddr = ridx_s1 - AW'(1);
			end
			ST_SHUP: begin
				// open a gap at the insert point, walking from the tail
				ram_re    = (ptr_q != pos_q);
				ram_raddr = AW'(ptr_q - CW'(1));
				ram_we    = rvld_s1;
				ram_waddr = ridx_s1 + AW'(1);
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = new_ent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) ridx_s1 <= ram_raddr;
	end

	// request latch; preemption swaps in the old runner's priority for the insert
	always_ff @(posedge clk) begin
		if (accept) begin
			in_id_q   <= caller_id;
			in_time_q <= job_time;
			in_prio_q <= job_priority;
		end else if ((state_q == ST_DECIDE) && preempt_go) begin
			in_prio_q <= run_prio_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			pos_q       <= '0;
			pre_q       <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= pps_pkg::STAT_RUN;
			run_valid_q <= 1'b0;
			run_id_q    <= '0;
			run_rem_q   <= '0;
			run_prio_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ptr_q   <= '0;
						pre_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ptr_q != count_q) begin
						ptr_q <= ptr_q + CW'(1);
					end else if (!rvld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					status_q <= pps_pkg::STAT_RUN;
					if (pre_q) begin
						// second pass done: insert old runner
						pos_q   <= flags.found ? CW'(pos_idx) : count_q;
						ptr_q   <= count_q;
						state_q <= ST_SHUP;
					end else if (is_fin) begin
						if (own) begin
							if (count_q == '0) begin
								run_valid_q <= 1'b0;
								run_id_q    <= '0;
								run_rem_q   <= '0;
								run_prio_q  <= '0;
								done_q      <= 1'b1;
								state_q     <= ST_IDLE;
							end else begin
								run_id_q   <= head.id;
								run_rem_q  <= head.tm;
								run_prio_q <= head.prio;
								ptr_q      <= CW'(1);
								state_q    <= ST_SHDN;
							end
						end else if (flags.hit) begin
							ptr_q   <= CW'(hit_idx) + CW'(1);
							state_q <= ST_SHDN;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (!run_valid_q) begin
						// idle block grants at once
						run_valid_q <= 1'b1;
						run_id_q    <= in_id_q;
						run_rem_q   <= in_time_q;
						run_prio_q  <= in_prio_q;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (own) begin
						if (flags.less) begin
							run_id_q   <= head.id;
							run_rem_q  <= head.tm;
							run_prio_q <= head.prio;
							pre_q      <= 1'b1;
							ptr_q      <= CW'(1);
							state_q    <= ST_SHDN;
						end else begin
							run_rem_q <= in_time_q;
							done_q    <= 1'b1;
							state_q   <= ST_IDLE;
						end
					end else if (flags.hit) begin
						status_q <= pps_pkg::STAT_WAIT;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else if (count_q == CW'(QUEUE_DEPTH)) begin
						status_q <= pps_pkg::STAT_FULL;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						status_q <= pps_pkg::STAT_WAIT;
						pos_q    <= flags.found ? CW'(pos_idx) : count_q;
						ptr_q    <= count_q;
						state_q  <= ST_SHUP;
					end
				end
				ST_SHDN: begin
					if (ptr_q != count_q) begin
						ptr_q <= ptr_q + CW'(1);
					end else if (!rvld_s1) begin
						count_q <= count_q - CW'(1);
						if (pre_q) begin
							ptr_q   <= '0;
							state_q <= ST_SCAN;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SHUP: begin
					if (ptr_q != pos_q) begin
						ptr_q <= ptr_q - CW'(1);
					end else if (!rvld_s1) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					count_q <= count_q + CW'(1);
					pre_q   <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	pps_ram #(
		.WIDTH ($bits(pps_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pps_scan #(
		.DEPTH (QUEUE_DEPTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (scan_clr),
		.vld      (scan_vld),
		.idx      (ridx_s1),
		.ent      (ram_rdata),
		.key_id   (in_id_q),
		.key_prio (in_prio_q),
		.run_prio (run_prio_q),
		.flags    (flags),
		.hit_idx  (hit_idx),
		.pos_idx  (pos_idx),
		.head     (head)
	);

	assign done          = done_q;
	assign status        = status_q;
	assign running_valid = run_valid_q;
	assign running_id    = run_id_q;

`ifndef SYNTHESIS
	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("wait queue count above depth");

	// an idle block has no waiters
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!run_valid_q |-> (count_q == '0))
		else $error("waiters present with no runner");

	// full status only when the queue really is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == pps_pkg::STAT_FULL)) |-> (count_q == CW'(QUEUE_DEPTH)))
		else $error("full status with free slot");

	// a queue insert grows the count by exactly one
	a_put_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow queue");

	// the result strobe comes only as the sequencer returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE) && !$past(state_q == ST_IDLE))
		else $error("result strobe outside item completion");
`endif

endmodule

// ===== bench/preemptive_priority_scheduler_unit_tb.sv =====
// Self-checking testbench for the preemptive priority scheduler: directed table, then random traffic.
`timescale 1ns / 100ps

module preemptive_priority_scheduler_unit_tb;

	localparam int DEPTH      = 16;    // must match the DUT's QUEUE_DEPTH
	localparam int N_RANDOM   = 1000;  // random requests after the table
	localparam int TAIL_WAIT  = 4 * DEPTH + 20;  // worst preemption pass plus margin
	localparam int STALL_MAX  = 2000;  // cycles with no word moving before giving up
	localparam int POOL_SIZE  = 24;    // more callers than queue slots, so the queue fills

	// one result word
	typedef struct packed {
		logic [pps_pkg::STAT_W-1:0] st;
		logic                       rv;
		logic [pps_pkg::ID_W-1:0]   rid;
	} sched_out_t;

	// one row of the directed table; want_fixed marks a typed-in expectation
	typedef struct packed {
		logic [pps_pkg::ID_W-1:0]   id;
		logic [pps_pkg::TIME_W-1:0] tm;
		logic [pps_pkg::PRIO_W-1:0] prio;
		logic                       want_fixed;
		sched_out_t                 want;
	} req_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [pps_pkg::ID_W-1:0]     caller_id;
	logic [pps_pkg::TIME_W-1:0]   job_time;
	logic [pps_pkg::PRIO_W-1:0]   job_priority;
	logic                         done;
	logic [pps_pkg::STAT_W-1:0]   status;
	logic                         running_valid;
	logic [pps_pkg::ID_W-1:0]     running_id;

	// --- predictor state: runner and sorted wait queue ---
	logic                       run_on;
	logic [pps_pkg::ID_W-1:0]   run_who;
	logic [pps_pkg::TIME_W-1:0] run_left;
	logic [pps_pkg::PRIO_W-1:0] run_rank;
	pps_pkg::entry_t            waitq[DEPTH];
	int                         wait_len;

	// --- scoreboard ---
	sched_out_t  pending_results[$];
	req_row_t    req_table[$];
	int          taken_count;      // requests accepted so far
	int          mismatch_count;
	int          quiet_cycles;     // watchdog counter

	// expectation typed into the row now on the request ports
	logic        row_fixed;
	sched_out_t  row_want;

	// random stimulus knobs
	logic [pps_pkg::ID_W-1:0] caller_pool[POOL_SIZE];
	int                       burst_left;   // items left in a no-gap stretch

	preemptive_priority_scheduler_unit #(
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.caller_id    (caller_id),
		.job_time     (job_time),
		.job_priority (job_priority),
		.done         (done),
		.status       (status),
		.running_valid(running_valid),
		.running_id   (running_id)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Predictor helpers
	// ------------------------------------------------------------------

	// index of a waiting caller, -1 if absent
	function automatic int find_waiter(input logic [pps_pkg::ID_W-1:0] id);
		int i;
		for (i = 0; i < wait_len; i++)
			if (waitq[i].id == id)
				return i;
		return -1;
	endfunction

	// close the gap left by entry pos
	function automatic void drop_waiter(input int pos);
		int i;
		for (i = pos; i + 1 < wait_len; i++)
			waitq[i] = waitq[i + 1];
		wait_len--;
	endfunction

	// insert behind all entries of equal or better priority; caller checks room
	function automatic void queue_sorted(input pps_pkg::entry_t e);
		int pos;
		int i;
		pos = 0;
		while (pos < wait_len && waitq[pos].prio <= e.prio)
			pos++;
		for (i = wait_len; i > pos; i--)
			waitq[i] = waitq[i - 1];
		waitq[pos] = e;
		wait_len++;
	endfunction

	// queue head becomes the runner
	function automatic void promote_head();
		run_on   = 1'b1;
		run_who  = waitq[0].id;
		run_left = waitq[0].tm;
		run_rank = waitq[0].prio;
		drop_waiter(0);
	endfunction

	// one request through the scheduler; updates state, returns the result word
	function automatic sched_out_t schedule_request(input logic [pps_pkg::ID_W-1:0] id,
		input logic [pps_pkg::TIME_W-1:0] t, input logic [pps_pkg::PRIO_W-1:0] p);
		sched_out_t      res;
		pps_pkg::entry_t e;
		int              hit;
		int              i;
		logic            beaten;
		res.st = pps_pkg::STAT_RUN;
		if (t == '0) begin
			if (run_on && id == run_who) begin
				// runner finished: hand over to the head, or go idle
				if (wait_len == 0) begin
					run_on   = 1'b0;
					run_who  = '0;
					run_left = '0;
					run_rank = '0;
				end else begin
					promote_head();
				end
			end else begin
				// withdraw a waiter; unknown caller changes nothing
				hit = find_waiter(id);
				if (hit >= 0)
					drop_waiter(hit);
			end
		end else if (!run_on) begin
			run_on   = 1'b1;
			run_who  = id;
			run_left = t;
			run_rank = p;
		end else if (id == run_who) begin
			// runner keeps its granted priority; only the time moves
			run_left = t;
			beaten = 1'b0;
			for (i = 0; i < wait_len; i++)
				if (waitq[i].prio < run_rank)
					beaten = 1'b1;
			if (beaten) begin
				e.id   = run_who;
				e.tm   = run_left;
				e.prio = run_rank;
				promote_head();
				queue_sorted(e);
			end
		end else begin
			hit = find_waiter(id);
			if (hit >= 0) begin
				// rewritten in place, no reordering
				waitq[hit].tm   = t;
				waitq[hit].prio = p;
				res.st = pps_pkg::STAT_WAIT;
			end else if (wait_len >= DEPTH) begin
				res.st = pps_pkg::STAT_FULL;
			end else begin
				e.id   = id;
				e.tm   = t;
				e.prio = p;
				queue_sorted(e);
				res.st = pps_pkg::STAT_WAIT;
			end
		end
		res.rv  = run_on;
		res.rid = run_on ? run_who : '0;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: results checked first, then the request of this edge predicted
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sched_out_t got;
		sched_out_t want;
		sched_out_t pred;
		if (arst_n) begin
			if (done) begin
				got.st  = status;
				got.rv  = running_valid;
				got.rid = running_id;
				if (pending_results.size() == 0) begin
					$display("%0t: result word with nothing expected: status %0d valid %0d id %h",
						$time, got.st, got.rv, got.rid);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
						mismatch_count++;
					end
					if (got.rv !== want.rv) begin
						$display("%0t: running_valid expected %0d actual %0d",
							$time, want.rv, got.rv);
						mismatch_count++;
					end
					if (got.rid !== want.rid) begin
						$display("%0t: running_id expected %h actual %h",
							$time, want.rid, got.rid);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				pred = schedule_request(caller_id, job_time, job_priority);
				pending_results.push_back(row_fixed ? row_want : pred);
				taken_count++;
			end
		end
	end

	// Watchdog: no request taken and no result seen for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic add_row(input logic [pps_pkg::ID_W-1:0] id,
		input logic [pps_pkg::TIME_W-1:0] t, input logic [pps_pkg::PRIO_W-1:0] p,
		input logic fixed, input logic [pps_pkg::STAT_W-1:0] st,
		input logic rv, input logic [pps_pkg::ID_W-1:0] rid);
		req_row_t r;
		r.id        = id;
		r.tm        = t;
		r.prio      = p;
		r.want_fixed = fixed;
		r.want.st   = st;
		r.want.rv   = rv;
		r.want.rid  = rid;
		req_table.push_back(r);
	endtask

	// present one request word after a random gap and wait until it is taken
	task automatic send_request(input logic [pps_pkg::ID_W-1:0] id,
		input logic [pps_pkg::TIME_W-1:0] t, input logic [pps_pkg::PRIO_W-1:0] p,
		input logic fixed, input sched_out_t want);
		int gap;
		int seen;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 14);
		end
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) begin
				// junk on the request ports while start is low
				caller_id    = pps_pkg::ID_W'($urandom);
				job_time     = pps_pkg::TIME_W'($urandom);
				job_priority = pps_pkg::PRIO_W'($urandom);
				@(negedge clk);
			end
		end
		caller_id    = id;
		job_time     = t;
		job_priority = p;
		row_fixed    = fixed;
		row_want     = want;
		start        = 1'b1;
		seen = taken_count;
		do
			@(negedge clk);
		while (taken_count == seen);
	endtask

	initial begin
		int                         i;
		int                         r;
		int                         zero_pct;
		logic [pps_pkg::ID_W-1:0]   id;
		logic [pps_pkg::TIME_W-1:0] t;
		logic [pps_pkg::PRIO_W-1:0] p;
		req_row_t                   row;

		// everything known from time zero
		arst_n       = 1'b0;
		start        = 1'b0;
		caller_id    = '0;
		job_time     = '0;
		job_priority = '0;
		row_fixed    = 1'b0;
		row_want     = '0;
		run_on       = 1'b0;
		run_who      = '0;
		run_left     = '0;
		run_rank     = '0;
		wait_len     = 0;
		for (i = 0; i < DEPTH; i++)
			waitq[i] = '0;
		taken_count    = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		burst_left     = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed table ---
		// zero time from an unknown caller while idle: id 0 must not match the cleared runner
		add_row(22'd0, 16'd0, 8'd0, 1'b1, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// idle grant, all-ones fields
		add_row(22'h3FFFFF, 16'hFFFF, 8'hFF, 1'b1, pps_pkg::STAT_RUN, 1'b1, 22'h3FFFFF);
		add_row(22'd1, 16'd1, 8'd0, 1'b1, pps_pkg::STAT_WAIT, 1'b1, 22'h3FFFFF);
		// runner update with a better waiter present: preempted, id 1 takes over
		add_row(22'h3FFFFF, 16'd100, 8'd0, 1'b1, pps_pkg::STAT_RUN, 1'b1, 22'd1);
		// equal priority goes behind, better one in front
		add_row(22'd2, 16'd5, 8'd255, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		add_row(22'd3, 16'd5, 8'd128, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// waiter rewritten in place, leaves the queue out of order
		add_row(22'd2, 16'd9, 8'd0, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// runner's priority field is ignored: no preemption
		add_row(22'd1, 16'd7, 8'd200, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// withdraw a waiter, then finish the runner
		add_row(22'd3, 16'd0, 8'd77, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		add_row(22'd1, 16'd0, 8'd0, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// preemption by the head that was updated in place
		add_row(22'h3FFFFF, 16'd1, 8'd0, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// fill the queue; repeated priorities to exercise ties
		for (i = 0; i < DEPTH - 1; i++)
			add_row(pps_pkg::ID_W'(10 + i), pps_pkg::TIME_W'(50 + i), {i[1:0], 6'd0},
				1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// new caller against a full queue
		add_row(22'd0, 16'd3, 8'd3, 1'b1, pps_pkg::STAT_FULL, 1'b1, 22'd2);
		// update of a waiter still works when full
		add_row(22'd10, 16'd2, 8'd1, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);
		// runner finishes with a full queue
		add_row(22'd2, 16'd0, 8'd0, 1'b0, pps_pkg::STAT_RUN, 1'b0, 22'd0);

		foreach (req_table[k]) begin
			row = req_table[k];
			send_request(row.id, row.tm, row.prio, row.want_fixed, row.want);
		end

		// --- random part ---
		caller_pool[0] = '0;
		caller_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			caller_pool[i] = pps_pkg::ID_W'($urandom);
		zero_pct = 15;
		for (i = 0; i < N_RANDOM; i++) begin
			// new phase: change the finish/withdraw rate and maybe start a gapless burst
			if (i % 150 == 0) begin
				case ($urandom_range(0, 3))
					0: zero_pct = 5;
					1: zero_pct = 15;
					2: zero_pct = 35;
					default: zero_pct = 60;
				endcase
			end
			if (burst_left == 0 && $urandom_range(0, 19) == 0)
				burst_left = $urandom_range(5, 30);

			// caller: runner, a current waiter, the pool, or an outsider
			r = $urandom_range(0, 99);
			if (r < 25 && run_on)
				id = run_who;
			else if (r < 50 && wait_len > 0)
				id = waitq[$urandom_range(0, wait_len - 1)].id;
			else if (r < 95)
				id = caller_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				id = pps_pkg::ID_W'($urandom);

			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < zero_pct)
				t = '0;
			else if (r < 10)
				t = '1;
			else if (r < 20)
				t = 16'd1;
			else
				t = pps_pkg::TIME_W'($urandom_range(1, 65535));

			// narrow priorities most of the time so ties and preemptions are common
			if ($urandom_range(0, 99) < 60)
				p = pps_pkg::PRIO_W'($urandom_range(0, 7));
			else
				p = pps_pkg::PRIO_W'($urandom);

			send_request(id, t, p, 1'b0, '0);
		end
		start = 1'b0;

		while (pending_results.size() != 0)
			@(negedge clk);
		// catch any stray result word
		repeat (TAIL_WAIT) @(negedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
